[hw/rtl/psca_pkg.sv]
package psca_pkg;

    localparam int MAX_SOURCES = 16;
    localparam int IDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int CNT_W = $clog2(MAX_SOURCES + 1);

    localparam int FUNC_W = 2;
    localparam int SID_W = 8;
    localparam int VAL_W = 16;
    localparam int ENTRY_W = SID_W + 2 * VAL_W;

    localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MEASURE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EVAL    = 2'd2;

    localparam logic signed [VAL_W-1:0] HELD_RESET = -16'sd100;
    localparam logic signed [VAL_W-1:0] HELD_CLEAR = 16'sd0;

    typedef struct packed {
        logic [SID_W-1:0]        src;
        logic signed [VAL_W-1:0] prio;
        logic signed [VAL_W-1:0] spd;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_APPEND,
        S_FIN
    } t_state;

    typedef struct packed {
        logic capture;
        logic scan_run;
        logic shift_start;
        logic shift_run;
        logic append;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic is_request;
        logic found;
        logic full;
        logic scan_done;
        logic shift_done;
        logic out_free;
    } t_dp_sts;

endpackage

[hw/rtl/psca_if.sv]
interface psca_in_if;
    logic                                       valid;
    logic                                       ready;
    logic [psca_pkg::FUNC_W-1:0]                func;
    logic [psca_pkg::SID_W-1:0]                 source_id;
    logic signed [psca_pkg::VAL_W-1:0]          request_priority;
    logic signed [psca_pkg::VAL_W-1:0]          request_speed;
    logic signed [psca_pkg::VAL_W-1:0]          measured_speed;

    modport source (output valid, func, source_id, request_priority, request_speed,
                    measured_speed, input ready);
    modport sink (input valid, func, source_id, request_priority, request_speed,
                  measured_speed, output ready);
endinterface

interface psca_out_if;
    logic                                       valid;
    logic                                       ready;
    logic                                       published;
    logic signed [psca_pkg::VAL_W-1:0]          target_out;
    logic signed [psca_pkg::VAL_W-1:0]          priority_out;
    logic [psca_pkg::SID_W-1:0]                 winner_out;
    logic                                       dropped;

    modport source (output valid, published, target_out, priority_out, winner_out,
                    dropped, input ready);
    modport sink (input valid, published, target_out, priority_out, winner_out,
                  dropped, output ready);
endinterface

[hw/rtl/psca_ram.sv]
module psca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[hw/rtl/psca_datapath.sv]
module psca_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  psca_pkg::t_dp_cmd                     i_cmd,
    output psca_pkg::t_dp_sts                     o_sts,
    input  logic [psca_pkg::FUNC_W-1:0]           i_func,
    input  logic [psca_pkg::SID_W-1:0]            i_source_id,
    input  logic signed [psca_pkg::VAL_W-1:0]     i_request_priority,
    input  logic signed [psca_pkg::VAL_W-1:0]     i_request_speed,
    input  logic signed [psca_pkg::VAL_W-1:0]     i_measured_speed,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic                                  o_published,
    output logic signed [psca_pkg::VAL_W-1:0]     o_target_out,
    output logic signed [psca_pkg::VAL_W-1:0]     o_priority_out,
    output logic [psca_pkg::SID_W-1:0]            o_winner_out,
    output logic                                  o_dropped
);

    localparam int IW = psca_pkg::IDX_W;
    localparam int CW = psca_pkg::CNT_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(psca_pkg::MAX_SOURCES);

    // captured word
    logic [psca_pkg::FUNC_W-1:0]       r_func;
    logic [psca_pkg::SID_W-1:0]        r_sid;
    logic signed [psca_pkg::VAL_W-1:0] r_prio;
    logic signed [psca_pkg::VAL_W-1:0] r_spd;
    logic signed [psca_pkg::VAL_W-1:0] r_meas;

    // arbiter state
    logic [CW-1:0]                     r_count;
    logic signed [psca_pkg::VAL_W-1:0] r_target;
    logic signed [psca_pkg::VAL_W-1:0] r_held;
    logic [psca_pkg::SID_W-1:0]        r_last;
    logic                              r_last_v;

    // walk over the table
    logic [CW-1:0] r_ptr;
    logic          r_chk_v;
    logic [IW-1:0] r_chk_idx;
    logic          r_found;
    logic [IW-1:0] r_fidx;
    logic          r_appended;
    logic          r_best_v;
    psca_pkg::t_entry r_best;

    // output register
    logic                              r_o_valid;
    logic                              r_o_pub;
    logic signed [psca_pkg::VAL_W-1:0] r_o_target;
    logic signed [psca_pkg::VAL_W-1:0] r_o_prio;
    logic [psca_pkg::SID_W-1:0]        r_o_winner;
    logic                              r_o_drop;

    logic [psca_pkg::ENTRY_W-1:0] w_rdata;
    psca_pkg::t_entry             w_rd;
    psca_pkg::t_entry             w_wentry;
    logic                         w_we;
    logic [IW-1:0]                w_waddr;
    logic [CW-1:0]                w_last_idx;
    logic                         w_rd_more;

    logic signed [psca_pkg::VAL_W-1:0] n_target;
    logic signed [psca_pkg::VAL_W-1:0] n_held;
    logic                              n_take;

    assign w_rd       = psca_pkg::t_entry'(w_rdata);
    assign w_rd_more  = (r_ptr < r_count);
    assign w_last_idx = r_count - CW'(1);

    always_comb begin
        w_wentry = w_rd;
        w_waddr  = r_chk_idx;
        w_we     = 1'b0;
        if (i_cmd.append) begin
            w_wentry.src  = r_sid;
            w_wentry.prio = r_prio;
            w_wentry.spd  = r_spd;
            w_waddr       = r_found ? w_last_idx[IW-1:0] : r_count[IW-1:0];
            w_we          = 1'b1;
        end else if (i_cmd.shift_run && r_chk_v) begin
            w_we = 1'b1;
        end
    end

    psca_ram #(
        .WIDTH (psca_pkg::ENTRY_W),
        .DEPTH (psca_pkg::MAX_SOURCES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wentry),
        .i_raddr (r_ptr[IW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_target = r_target;
        n_held   = r_held;
        n_take   = 1'b0;
        case (r_func)
            psca_pkg::FUNC_MEASURE: begin
                if (r_meas == r_target) begin
                    n_held = psca_pkg::HELD_CLEAR;
                end
            end
            psca_pkg::FUNC_EVAL: begin
                n_take = r_best_v && ((r_last_v && (r_last == r_best.src))
                                      || (r_best.prio >= r_held));
                if (n_take) begin
                    n_target = r_best.spd;
                    n_held   = r_best.prio;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_sid  <= i_source_id;
            r_prio <= i_request_priority;
            r_spd  <= i_request_speed;
            r_meas <= i_measured_speed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_target   <= '0;
            r_held     <= psca_pkg::HELD_RESET;
            r_last_v   <= 1'b0;
            r_ptr      <= '0;
            r_chk_v    <= 1'b0;
            r_found    <= 1'b0;
            r_appended <= 1'b0;
            r_best_v   <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_ptr      <= '0;
                r_chk_v    <= 1'b0;
                r_found    <= 1'b0;
                r_appended <= 1'b0;
                r_best_v   <= 1'b0;
            end else if (i_cmd.shift_start) begin
                r_ptr   <= CW'(r_fidx) + CW'(1);
                r_chk_v <= 1'b0;
            end else if (i_cmd.scan_run || i_cmd.shift_run) begin
                // issue one read a cycle, look at its data in the next cycle
                if (w_rd_more) begin
                    r_ptr     <= r_ptr + CW'(1);
                    r_chk_v   <= 1'b1;
                    r_chk_idx <= i_cmd.shift_run ? IW'(r_ptr - CW'(1)) : r_ptr[IW-1:0];
                end else begin
                    r_chk_v <= 1'b0;
                end
                if (i_cmd.scan_run && r_chk_v) begin
                    if (w_rd.src == r_sid) begin
                        r_found <= 1'b1;
                        r_fidx  <= r_chk_idx;
                    end
                    if (!r_best_v || (w_rd.prio >= r_best.prio)) begin
                        r_best_v <= 1'b1;
                        r_best   <= w_rd;
                    end
                end
            end

            if (i_cmd.append) begin
                r_appended <= 1'b1;
                if (!r_found) begin
                    r_count <= r_count + CW'(1);
                end
            end

            if (i_cmd.finish) begin
                r_target   <= n_target;
                r_held     <= n_held;
                if ((r_func == psca_pkg::FUNC_EVAL) && r_best_v) begin
                    r_last   <= r_best.src;
                    r_last_v <= 1'b1;
                end
                r_o_valid  <= 1'b1;
                r_o_pub    <= (r_func == psca_pkg::FUNC_EVAL) && r_best_v;
                r_o_target <= n_target;
                r_o_prio   <= n_held;
                r_o_winner <= ((r_func == psca_pkg::FUNC_EVAL) && r_best_v) ? r_best.src : '0;
                r_o_drop   <= (r_func == psca_pkg::FUNC_REQUEST) && !r_appended;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_sts.is_request = (r_func == psca_pkg::FUNC_REQUEST);
    assign o_sts.found      = r_found;
    assign o_sts.full       = (r_count >= MAX_CNT);
    assign o_sts.scan_done  = !w_rd_more && !r_chk_v;
    assign o_sts.shift_done = !w_rd_more && !r_chk_v;
    assign o_sts.out_free   = !r_o_valid || i_out_ready;

    assign o_out_valid    = r_o_valid;
    assign o_published    = r_o_pub;
    assign o_target_out   = r_o_target;
    assign o_priority_out = r_o_prio;
    assign o_winner_out   = r_o_winner;
    assign o_dropped      = r_o_drop;

endmodule

[hw/rtl/psca_ctrl.sv]
module psca_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  psca_pkg::t_dp_sts  i_sts,
    output psca_pkg::t_dp_cmd  o_cmd
);

    psca_pkg::t_state r_state;
    psca_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psca_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            psca_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = psca_pkg::S_SCAN;
                end
            end
            psca_pkg::S_SCAN: begin
                if (i_sts.scan_done) begin
                    if (!i_sts.is_request) begin
                        n_state = psca_pkg::S_FIN;
                    end else if (i_sts.found) begin
                        n_state = psca_pkg::S_SHIFT;
                    end else if (i_sts.full) begin
                        n_state = psca_pkg::S_FIN;
                    end else begin
                        n_state = psca_pkg::S_APPEND;
                    end
                end
            end
            psca_pkg::S_SHIFT: begin
                if (i_sts.shift_done) begin
                    n_state = psca_pkg::S_APPEND;
                end
            end
            psca_pkg::S_APPEND: begin
                n_state = psca_pkg::S_FIN;
            end
            psca_pkg::S_FIN: begin
                if (i_sts.out_free) begin
                    n_state = psca_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = psca_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            psca_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            psca_pkg::S_SCAN: begin
                o_cmd.scan_run    = 1'b1;
                // compact the entries above the old one before re-appending
                o_cmd.shift_start = i_sts.scan_done && i_sts.is_request && i_sts.found;
            end
            psca_pkg::S_SHIFT: begin
                o_cmd.shift_run = 1'b1;
            end
            psca_pkg::S_APPEND: begin
                o_cmd.append = 1'b1;
            end
            psca_pkg::S_FIN: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

[hw/rtl/priority_speed_command_arbiter_top.sv]
// Priority speed command arbiter.
// Input channel i_cmd carries one word per command: a speed request (source id,
// priority, speed), a measured speed report, or an evaluate. Output channel o_res
// returns exactly one result word per command, in order.
// Requests keep a table of up to MAX_SOURCES entries in write order; a repeat
// source moves to the end with its new values, a new source on a full table is
// refused and flagged. Evaluate picks the highest priority, latest on a tie.
// Stepping: the table sits in a single-port-read RAM and is walked one entry per
// cycle; every command scans the whole table before its result is written. A
// request that appends adds an append step; a replacing request at index k first
// compacts the entries above k one place down, then appends.
// One command is in flight at a time: a new command is taken only after the last
// one has written its result.
// The result sits in an output register; while the receiver stalls the next
// command is still accepted and worked, and waits at its end for the register.
// Synchronous reset empties the table, sets target to 0, held priority to -100
// and forgets the last winner. Table contents are not cleared.
module priority_speed_command_arbiter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    psca_in_if.sink     i_cmd,
    psca_out_if.source  o_res
);

    psca_pkg::t_dp_cmd w_cmd;
    psca_pkg::t_dp_sts w_sts;
    logic              w_in_ready;

    assign i_cmd.ready = w_in_ready;

    psca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    psca_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_func             (i_cmd.func),
        .i_source_id        (i_cmd.source_id),
        .i_request_priority (i_cmd.request_priority),
        .i_request_speed    (i_cmd.request_speed),
        .i_measured_speed   (i_cmd.measured_speed),
        .i_out_ready        (o_res.ready),
        .o_out_valid        (o_res.valid),
        .o_published        (o_res.published),
        .o_target_out       (o_res.target_out),
        .o_priority_out     (o_res.priority_out),
        .o_winner_out       (o_res.winner_out),
        .o_dropped          (o_res.dropped)
    );

endmodule

[hw/rtl/psca_check.sv]
module psca_check (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic                              i_published,
    input logic signed [psca_pkg::VAL_W-1:0] i_target_out,
    input logic signed [psca_pkg::VAL_W-1:0] i_priority_out,
    input logic [psca_pkg::SID_W-1:0]        i_winner_out,
    input logic                              i_dropped
);

    // hold a stalled result word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_published)
            && $stable(i_target_out) && $stable(i_priority_out)
            && $stable(i_winner_out) && $stable(i_dropped))
        else $error("result word changed while stalled");

    a_pub_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_published && i_dropped))
        else $error("published and dropped in one word");

    a_winner_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_published |-> i_winner_out == '0)
        else $error("winner shown without publish");

    // a result never appears right after its command is taken
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result word too early");

endmodule

bind priority_speed_command_arbiter_top psca_check u_psca_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_cmd.valid),
    .i_in_ready     (i_cmd.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_published    (o_res.published),
    .i_target_out   (o_res.target_out),
    .i_priority_out (o_res.priority_out),
    .i_winner_out   (o_res.winner_out),
    .i_dropped      (o_res.dropped)
);

[sim/psca_checker.sv]
`timescale 1ns / 100ps
module psca_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    psca_in_if   i_cmd,
    psca_out_if  i_res,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked,
    output int   o_refused
);
    import psca_pkg::*;

    typedef struct packed {
        logic                    published;
        logic signed [VAL_W-1:0] target;
        logic signed [VAL_W-1:0] prio;
        logic [SID_W-1:0]        winner;
        logic                    dropped;
    } t_result;

    // Model of the request table, kept in write order.
    t_entry                  speed_table [MAX_SOURCES];
    int                      fill;
    logic signed [VAL_W-1:0] target_speed;
    logic signed [VAL_W-1:0] held_prio;
    logic [SID_W-1:0]        prev_winner;
    logic                    prev_winner_ok;

    t_result results_due [$];
    int      error_count;
    int      checked_count;
    int      refused_count;

    initial begin
        error_count   = 0;
        checked_count = 0;
        refused_count = 0;
        o_errors      = 0;
        o_pending     = 0;
        o_checked     = 0;
        o_refused     = 0;
    end

    function automatic t_result arbitrate_word(
        logic [FUNC_W-1:0]       func,
        logic [SID_W-1:0]        sid,
        logic signed [VAL_W-1:0] req_prio,
        logic signed [VAL_W-1:0] req_spd,
        logic signed [VAL_W-1:0] meas
    );
        t_result r;
        int      i;
        int      hit;
        int      best;
        r = '0;
        case (func)
            FUNC_REQUEST: begin
                hit = fill;
                for (i = 0; i < fill; i++) begin
                    if (hit == fill && speed_table[i].src == sid) hit = i;
                end
                if (hit == fill && fill >= MAX_SOURCES) begin
                    r.dropped = 1'b1;
                end else begin
                    // A repeat source leaves its slot and moves to the end.
                    if (hit < fill) begin
                        for (i = hit; i + 1 < fill; i++) speed_table[i] = speed_table[i + 1];
                        fill = fill - 1;
                    end
                    speed_table[fill] = '{src: sid, prio: req_prio, spd: req_spd};
                    fill = fill + 1;
                end
            end
            FUNC_MEASURE: begin
                if (meas == target_speed) held_prio = HELD_CLEAR;
            end
            FUNC_EVAL: begin
                if (fill > 0) begin
                    best = 0;
                    // Ties go to the latest written entry.
                    for (i = 1; i < fill; i++) begin
                        if ($signed(speed_table[i].prio) >= $signed(speed_table[best].prio))
                            best = i;
                    end
                    if (prev_winner_ok && prev_winner == speed_table[best].src) begin
                        target_speed = speed_table[best].spd;
                        held_prio    = speed_table[best].prio;
                    end else begin
                        if ($signed(speed_table[best].prio) >= $signed(held_prio)) begin
                            target_speed = speed_table[best].spd;
                            held_prio    = speed_table[best].prio;
                        end
                        prev_winner    = speed_table[best].src;
                        prev_winner_ok = 1'b1;
                    end
                    r.published = 1'b1;
                    r.winner    = speed_table[best].src;
                end
            end
            default: begin
            end
        endcase
        r.target = target_speed;
        r.prio   = held_prio;
        return r;
    endfunction

    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            fill           = 0;
            target_speed   = '0;
            held_prio      = HELD_RESET;
            prev_winner    = '0;
            prev_winner_ok = 1'b0;
        end else begin
            // Retire the oldest result before the new command is predicted.
            if (i_res.valid && i_res.ready) begin
                if (results_due.size() == 0) begin
                    $error("result word with no command outstanding");
                    error_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("published", want.published, i_res.published);
                    check_field("target_out", want.target, i_res.target_out);
                    check_field("priority_out", want.prio, i_res.priority_out);
                    check_field("winner_out", want.winner, i_res.winner_out);
                    check_field("dropped", want.dropped, i_res.dropped);
                    checked_count++;
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                want = arbitrate_word(i_cmd.func, i_cmd.source_id, i_cmd.request_priority,
                                      i_cmd.request_speed, i_cmd.measured_speed);
                if (want.dropped) refused_count++;
                results_due.insert(results_due.size(), want);
            end
        end
        o_errors  <= error_count;
        o_pending <= results_due.size();
        o_checked <= checked_count;
        o_refused <= refused_count;
    end

endmodule

[sim/tb_priority_speed_command_arbiter_top.sv]
`timescale 1ns / 100ps
module tb_priority_speed_command_arbiter_top;
    import psca_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    localparam int IDLE_PCT     = 29;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_WORDS = 900;
    localparam int CALM_FIRST   = 300;
    localparam int CALM_LAST    = 450;
    localparam int HOLD_AFTER   = 600;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int TIMEOUT_NS   = 5_000_000;

    logic clk = 1'b0;
    logic rst_n;
    logic calm;
    int   sent_words;
    int   sent_requests;
    int   sent_reports;
    int   sent_evals;
    int   sent_unused;
    int   err_count;
    int   pending;
    int   checked;
    int   refused;

    psca_in_if  cmd_if ();
    psca_out_if res_if ();

    priority_speed_command_arbiter_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    psca_checker u_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cmd     (cmd_if),
        .i_res     (res_if),
        .o_errors  (err_count),
        .o_pending (pending),
        .o_checked (checked),
        .o_refused (refused)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Small values with chance near_pct percent so that ties, matches and repeats are frequent.
    function automatic logic signed [VAL_W-1:0] pick_value(int unsigned near_pct);
        int v;
        if ($urandom_range(0, 99) < near_pct) v = int'($urandom_range(0, 8)) - 4;
        else v = int'($urandom);
        return VAL_W'(v);
    endfunction

    task automatic send_word(input logic [FUNC_W-1:0] func, input logic [SID_W-1:0] sid,
                             input logic signed [VAL_W-1:0] prio,
                             input logic signed [VAL_W-1:0] spd,
                             input logic signed [VAL_W-1:0] meas);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid            <= 1'b1;
        cmd_if.func             <= func;
        cmd_if.source_id        <= sid;
        cmd_if.request_priority <= prio;
        cmd_if.request_speed    <= spd;
        cmd_if.measured_speed   <= meas;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        sent_words++;
        case (func)
            FUNC_REQUEST: sent_requests++;
            FUNC_MEASURE: sent_reports++;
            FUNC_EVAL:    sent_evals++;
            default:      sent_unused++;
        endcase
    endtask

    // Receiver: random stalls, one long hold-off once HOLD_AFTER words are sent.
    initial begin
        logic held_off;
        held_off = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!held_off && sent_words >= HOLD_AFTER) begin
                held_off = 1'b1;
                repeat (HOLD_CYCLES) begin
                    res_if.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            res_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        int                i;
        int                roll;
        int                sid_base;
        logic [FUNC_W-1:0] func;
        logic [SID_W-1:0]  sid;

        calm          = 1'b0;
        sent_words    = 0;
        sent_requests = 0;
        sent_reports  = 0;
        sent_evals    = 0;
        sent_unused   = 0;
        sid_base      = 0;
        rst_n                   <= 1'b0;
        cmd_if.valid            <= 1'b0;
        cmd_if.func             <= FUNC_REQUEST;
        cmd_if.source_id        <= '0;
        cmd_if.request_priority <= '0;
        cmd_if.request_speed    <= '0;
        cmd_if.measured_speed   <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table, unused code, report matching the reset target.
        send_word(FUNC_EVAL, 8'd0, 16'sd0, 16'sd0, 16'sd0);
        send_word(FUNC_NONE, 8'hff, -16'sd1, -16'sd1, -16'sd1);
        send_word(FUNC_MEASURE, 8'd0, 16'sd0, 16'sd0, 16'sd0);
        send_word(FUNC_REQUEST, 8'd0, -16'sd32768, 16'sd32767, 16'sd0);
        send_word(FUNC_REQUEST, 8'd255, 16'sd32767, -16'sd32768, 16'sd0);
        send_word(FUNC_EVAL, 8'd0, 16'sd0, 16'sd0, 16'sd0);
        // Replace the winner, then re-evaluate: same winner adopted outright.
        send_word(FUNC_REQUEST, 8'd255, -16'sd5, 16'sd7, 16'sd0);
        send_word(FUNC_EVAL, 8'd0, 16'sd0, 16'sd0, 16'sd0);
        // Equal priority: the latest written wins.
        send_word(FUNC_REQUEST, 8'd0, -16'sd5, 16'sd1, 16'sd0);
        send_word(FUNC_EVAL, 8'd0, 16'sd0, 16'sd0, 16'sd0);
        // Clear held priority, then a new winner below it is refused once.
        send_word(FUNC_MEASURE, 8'd0, 16'sd0, 16'sd0, 16'sd1);
        send_word(FUNC_REQUEST, 8'd9, -16'sd1, 16'sd5, 16'sd0);
        send_word(FUNC_EVAL, 8'd0, 16'sd0, 16'sd0, 16'sd0);
        send_word(FUNC_EVAL, 8'd0, 16'sd0, 16'sd0, 16'sd0);
        // Fill the table, overflow it, then replace an entry while full.
        for (i = 0; i < MAX_SOURCES - 3; i++)
            send_word(FUNC_REQUEST, SID_W'(100 + i), pick_value(100), pick_value(100), 16'sd0);
        send_word(FUNC_REQUEST, 8'd200, 16'sd32767, 16'sd3, 16'sd0);
        send_word(FUNC_REQUEST, 8'd0, 16'sd32767, 16'sd3, 16'sd0);
        send_word(FUNC_EVAL, 8'd0, 16'sd0, 16'sd0, 16'sd0);

        for (i = 0; i < RANDOM_WORDS; i++) begin
            calm = (i >= CALM_FIRST && i < CALM_LAST);
            // Slide a window of ids a little wider than the table.
            if (i % 64 == 0) sid_base = $urandom_range(0, 236);
            roll = $urandom_range(0, 99);
            if (roll < 50)      func = FUNC_REQUEST;
            else if (roll < 65) func = FUNC_MEASURE;
            else if (roll < 97) func = FUNC_EVAL;
            else                func = FUNC_NONE;
            if ($urandom_range(0, 9) == 0) sid = SID_W'($urandom);
            else sid = SID_W'(sid_base + $urandom_range(0, 19));
            send_word(func, sid, pick_value(60), pick_value(50), pick_value(50));
        end
        calm = 1'b0;
        cmd_if.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands: %0d requests, %0d speed reports, %0d evaluates, %0d unused.",
                 sent_words, sent_requests, sent_reports, sent_evals, sent_unused);
        $display("Compared %0d result words; %0d requests refused on a full table.",
                 checked, refused);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("Timeout: run did not drain");
        $display("DONE: errors detected");
        $finish;
    end

endmodule
